// File: design/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

    localparam int DEPTH      = 256;
    localparam int ELEM_BITS  = 32;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int POS_BITS   = 8;
    localparam int VALUE_BITS = 32;
    localparam int DATA_BITS  = 32;
    localparam int ICNT_BITS  = 9;
    localparam int CMP_BITS   = ((POS_BITS > CNT_BITS) ? POS_BITS : CNT_BITS) + 1;

    typedef logic [ELEM_BITS-1:0]  elem_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [CNT_BITS-1:0]   count_t;
    typedef logic [POS_BITS-1:0]   pos_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [DATA_BITS-1:0]  data_t;
    typedef logic [ICNT_BITS-1:0]  icount_t;
    typedef logic [CMP_BITS-1:0]   cmp_t;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_GET    = 3'd1,
        OP_SET    = 3'd2,
        OP_POP    = 3'd3,
        OP_FIND   = 3'd4
    } op_e;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_e;

    typedef struct packed {
        logic [2:0] req_type;
        pos_t       position;
        value_t     value;
    } req_t;

    typedef struct packed {
        status_e status;
        data_t   read_data;
        pos_t    found_position;
        icount_t item_count;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    wr_tail;
        logic    wr_pos;
        logic    wr_shift;
        logic    rd_pos;
        logic    rd_zero;
        logic    rd_next;
        logic    rd_skip;
        logic    idx_from_pos;
        logic    idx_zero;
        logic    idx_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_status;
        status_e status;
        logic    take_data;
        logic    take_found;
        logic    out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] req_type;
        logic       in_range;
        logic       is_full;
        logic       is_empty;
        logic       next_ok;
        logic       next2_ok;
        logic       match;
        logic       out_free;
    } sts_t;

endpackage

// File: design/ils_ram.sv
`timescale 1ns / 1ps

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ils_ctrl.sv
`timescale 1ns / 1ps

module ils_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ils_pkg::sts_t sts,
    output ils_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_GETW = 7'b0000100,
        S_POPT = 7'b0001000,
        S_POPS = 7'b0010000,
        S_FIND = 7'b0100000,
        S_DONE = 7'b1000000
    } state_e;

    state_e state_reg;
    state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.status = ils_pkg::ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (sts.req_type)
                    ils_pkg::OP_APPEND:
                    begin
                        if (sts.is_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ils_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_tail = 1'b1;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    ils_pkg::OP_GET:
                    begin
                        if (!sts.in_range)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ils_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_GETW;
                        end
                    end
                    ils_pkg::OP_SET:
                    begin
                        if (!sts.in_range)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ils_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cmd.wr_pos = 1'b1;
                        end
                    end
                    ils_pkg::OP_POP:
                    begin
                        if (!sts.in_range)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ils_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cmd.rd_pos       = 1'b1;
                            cmd.idx_from_pos = 1'b1;
                            state_next       = S_POPT;
                        end
                    end
                    ils_pkg::OP_FIND:
                    begin
                        if (sts.is_empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ils_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.rd_zero  = 1'b1;
                            cmd.idx_zero = 1'b1;
                            state_next   = S_FIND;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_GETW:
            begin
                cmd.take_data = 1'b1;
                state_next    = S_DONE;
            end
            S_POPT:
            begin
                cmd.take_data = 1'b1;
                if (sts.next_ok)
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_POPS;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_POPS:
            begin
                // The element one above the index moves down while the one after it is read.
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                if (sts.next2_ok)
                begin
                    cmd.rd_skip = 1'b1;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_FIND:
            begin
                if (sts.match)
                begin
                    cmd.take_found = 1'b1;
                    state_next     = S_DONE;
                end
                else if (sts.next_ok)
                begin
                    cmd.rd_next = 1'b1;
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ils_pkg::ST_NOTFOUND;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/ils_dp.sv
`timescale 1ns / 1ps

module ils_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  ils_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ils_pkg::rsp_t rsp,
    input  ils_pkg::cmd_t cmd,
    output ils_pkg::sts_t sts
);

    ils_pkg::req_t    req_reg;
    ils_pkg::count_t  count_reg;
    ils_pkg::count_t  count_next;
    ils_pkg::addr_t   idx_reg;
    ils_pkg::addr_t   idx_next;
    ils_pkg::status_e res_status_reg;
    ils_pkg::elem_t   res_data_reg;
    ils_pkg::addr_t   res_found_reg;
    logic             out_valid_reg;
    ils_pkg::rsp_t    out_reg;

    ils_pkg::elem_t   key;
    ils_pkg::cmp_t    count_cmp;
    ils_pkg::cmp_t    idx_p1;
    ils_pkg::cmp_t    idx_p2;
    logic             mem_we;
    ils_pkg::addr_t   mem_waddr;
    ils_pkg::elem_t   mem_wdata;
    logic             mem_re;
    ils_pkg::addr_t   mem_raddr;
    ils_pkg::elem_t   mem_rdata;

    assign key       = ils_pkg::elem_t'(req_reg.value);
    assign count_cmp = ils_pkg::cmp_t'(count_reg);
    assign idx_p1    = ils_pkg::cmp_t'(idx_reg) + ils_pkg::cmp_t'(1);
    assign idx_p2    = ils_pkg::cmp_t'(idx_reg) + ils_pkg::cmp_t'(2);

    always_comb
    begin
        mem_we    = cmd.wr_tail | cmd.wr_pos | cmd.wr_shift;
        mem_waddr = idx_reg;
        mem_wdata = mem_rdata;
        priority if (cmd.wr_tail)
        begin
            mem_waddr = ils_pkg::addr_t'(count_reg);
            mem_wdata = key;
        end
        else if (cmd.wr_pos)
        begin
            mem_waddr = ils_pkg::addr_t'(req_reg.position);
            mem_wdata = key;
        end
        else
        begin
            mem_waddr = idx_reg;
            mem_wdata = mem_rdata;
        end
    end

    always_comb
    begin
        mem_re    = cmd.rd_pos | cmd.rd_zero | cmd.rd_next | cmd.rd_skip;
        priority if (cmd.rd_pos)
        begin
            mem_raddr = ils_pkg::addr_t'(req_reg.position);
        end
        else if (cmd.rd_next)
        begin
            mem_raddr = ils_pkg::addr_t'(idx_p1);
        end
        else if (cmd.rd_skip)
        begin
            mem_raddr = ils_pkg::addr_t'(idx_p2);
        end
        else
        begin
            mem_raddr = '0;
        end
    end

    ils_ram #(
        .WIDTH(ils_pkg::ELEM_BITS),
        .DEPTH(ils_pkg::DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        priority if (cmd.cnt_inc)
        begin
            count_next = count_reg + ils_pkg::count_t'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - ils_pkg::count_t'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        priority if (cmd.idx_from_pos)
        begin
            idx_next = ils_pkg::addr_t'(req_reg.position);
        end
        else if (cmd.idx_zero)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = ils_pkg::addr_t'(idx_p1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load_req)
        begin
            req_reg        <= req;
            res_status_reg <= ils_pkg::ST_OK;
            res_data_reg   <= '0;
            res_found_reg  <= '0;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
        if (cmd.take_data)
        begin
            res_data_reg <= mem_rdata;
        end
        if (cmd.take_found)
        begin
            res_found_reg <= idx_reg;
        end
        if (cmd.out_load)
        begin
            out_reg.status         <= res_status_reg;
            out_reg.read_data      <= ils_pkg::data_t'(res_data_reg);
            out_reg.found_position <= ils_pkg::pos_t'(res_found_reg);
            out_reg.item_count     <= ils_pkg::icount_t'(count_reg);
        end
    end

    always_comb
    begin
        sts.req_type = req_reg.req_type;
        sts.in_range = ils_pkg::cmp_t'(req_reg.position) < count_cmp;
        sts.is_full  = (count_reg == ils_pkg::count_t'(ils_pkg::DEPTH));
        sts.is_empty = (count_reg == '0);
        sts.next_ok  = idx_p1 < count_cmp;
        sts.next2_ok = idx_p2 < count_cmp;
        sts.match    = (mem_rdata == key);
        sts.out_free = !out_valid_reg || !rsp_stall;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// File: design/indexed_list_store_core.sv
`timescale 1ns / 1ps

// Fixed-capacity list of elements held in one single-port-write RAM, plus a count.
// The request channel (req_valid, req_stall, req) carries one operation: append,
// get, set, pop or find. The response channel (rsp_valid, rsp_stall, rsp) returns
// exactly one response per request, in order, with status, read data, the found
// position and the element count after the request.
// Requests are handled one at a time. A request is taken only while the controller
// is idle; it then runs in the datapath and its response is placed in an output
// register. Append, set, out-of-range and unused requests finish in the execute state;
// get then waits for the RAM read; pop reads the element, then moves each element
// above the position down by one, one RAM read and write per element; find compares
// the elements from position 0 onward until a match or the count is reached.
// A new request is accepted while the previous response still waits in the output
// register. When rsp_stall is high the response holds, and a finished request waits
// for the register to free before the controller goes idle again.
// Reset clears the count and all control state; the element storage is not cleared,
// since only entries below the count are ever read.
module indexed_list_store_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ils_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ils_pkg::rsp_t rsp
);

    ils_pkg::cmd_t cmd;
    ils_pkg::sts_t sts;

    ils_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ils_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// File: design/ils_chk.sv
`timescale 1ns / 1ps

module ils_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input ils_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input ils_pkg::rsp_t rsp
);

    // A taken request keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while a previous one was still starting");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed or dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.item_count <= ils_pkg::icount_t'(ils_pkg::DEPTH)))
        else $error("element count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ils_pkg::ST_FULL)
            |-> (rsp.item_count == ils_pkg::icount_t'(ils_pkg::DEPTH)))
        else $error("full status with free slots left");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ils_pkg::ST_OK)
            |-> (rsp.read_data == '0 && rsp.found_position == '0))
        else $error("failed request returned data");

endmodule

bind indexed_list_store_core ils_chk u_ils_chk (.*);

// File: test/indexed_list_store_core_tb.sv
`timescale 1ns / 1ps

module indexed_list_store_core_tb;

    localparam int FIRST_UNUSED_OP = 5;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AFTER_RSP  = 150;
    localparam int TAIL_CYCLES     = 300;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    ils_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    ils_pkg::rsp_t rsp;

    // Expected contents of the list, updated in request order.
    ils_pkg::elem_t list_mem [ils_pkg::DEPTH];
    int             list_count = 0;

    ils_pkg::req_t  req_backlog[$];
    ils_pkg::rsp_t  rsp_owed[$];
    ils_pkg::rsp_t  pred_rsp;
    ils_pkg::rsp_t  want;

    // Rough count seen by the stimulus planner, used to shape positions and to steer the fill and drain loops.
    int    plan_count = 0;

    int    burst_left = 8;
    int    gap_left   = 0;
    int    hold_left  = 0;
    bit    hold_armed = 1'b1;
    int    mode_left  = 0;
    int    stall_mode = 0;
    int    stall_tick = 0;

    int    rsp_done       = 0;
    int    mismatch_count = 0;
    int    op_tally [8];
    int    full_refusals  = 0;
    int    find_misses    = 0;
    int    peak_count     = 0;

    ils_pkg::value_t value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                        32'h8000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                        32'h1234_5678, 32'h7FFF_FFFF};

    indexed_list_store_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic ils_pkg::rsp_t apply_to_list(input ils_pkg::req_t r);
        ils_pkg::rsp_t  out;
        int             slot;
        ils_pkg::elem_t key;
        out  = '0;
        slot = int'(r.position);
        key  = ils_pkg::elem_t'(r.value);
        case (r.req_type)
            ils_pkg::OP_APPEND:
            begin
                if (list_count >= ils_pkg::DEPTH)
                    out.status = ils_pkg::ST_FULL;
                else
                begin
                    list_mem[list_count] = key;
                    list_count++;
                end
            end
            ils_pkg::OP_GET:
            begin
                if (slot >= list_count)
                    out.status = ils_pkg::ST_RANGE;
                else
                    out.read_data = ils_pkg::data_t'(list_mem[slot]);
            end
            ils_pkg::OP_SET:
            begin
                if (slot >= list_count)
                    out.status = ils_pkg::ST_RANGE;
                else
                    list_mem[slot] = key;
            end
            ils_pkg::OP_POP:
            begin
                if (slot >= list_count)
                    out.status = ils_pkg::ST_RANGE;
                else
                begin
                    out.read_data = ils_pkg::data_t'(list_mem[slot]);
                    for (int i = slot; i < list_count - 1; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_count--;
                end
            end
            ils_pkg::OP_FIND:
            begin
                out.status = ils_pkg::ST_NOTFOUND;
                for (int i = 0; i < list_count && out.status == ils_pkg::ST_NOTFOUND; i++)
                begin
                    if (list_mem[i] == key)
                    begin
                        out.status         = ils_pkg::ST_OK;
                        out.found_position = ils_pkg::pos_t'(i);
                    end
                end
            end
            default:
                ;
        endcase
        out.item_count = ils_pkg::icount_t'(list_count);
        return out;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (mismatch_count < 50)
            $display("%0t ns: mismatch in %s at response %0d: got %0h, want %0h",
                     $realtime, what, rsp_done, got, exp_val);
        mismatch_count++;
    endtask

    function automatic ils_pkg::value_t pick_value();
        if ($urandom_range(0, 9) < 5)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic int pick_pos();
        if (plan_count > 0 && $urandom_range(0, 9) < 8)
            return $urandom_range(0, plan_count - 1);
        return $urandom_range(0, 255);
    endfunction

    task automatic plan_req(input logic [2:0] code, input int pos,
                            input ils_pkg::value_t val);
        ils_pkg::req_t r;
        r.req_type = code;
        r.position = ils_pkg::pos_t'(pos);
        r.value    = val;
        req_backlog.push_back(r);
        if (code == ils_pkg::OP_APPEND && plan_count < ils_pkg::DEPTH)
            plan_count++;
        else if (code == ils_pkg::OP_POP && pos < plan_count)
            plan_count--;
    endtask

    task automatic plan_random(input int n, input int grow_pct, input int shrink_pct);
        int         roll;
        logic [2:0] code;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                code = 3'(FIRST_UNUSED_OP + $urandom_range(0, 2));
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < grow_pct)
                    code = ils_pkg::OP_APPEND;
                else if (roll < grow_pct + shrink_pct)
                    code = ils_pkg::OP_POP;
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       code = ils_pkg::OP_GET;
                        1:       code = ils_pkg::OP_SET;
                        default: code = ils_pkg::OP_FIND;
                    endcase
                end
            end
            plan_req(code, pick_pos(), pick_value());
        end
    endtask

    // Waits until everything queued has been sent and answered.
    task automatic wait_idle();
        @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || rsp_owed.size() != 0)
            @(negedge clk);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                pred_rsp = apply_to_list(req);
                rsp_owed.push_back(pred_rsp);
                op_tally[req.req_type]++;
                if (pred_rsp.status == ils_pkg::ST_FULL)
                    full_refusals++;
                if (pred_rsp.status == ils_pkg::ST_NOTFOUND)
                    find_misses++;
                if (int'(pred_rsp.item_count) > peak_count)
                    peak_count = int'(pred_rsp.item_count);
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0 || req_backlog.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    req_valid <= 1'b0;
                end
                else
                begin
                    req       <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            8, 9:       gap_left = $urandom_range(10, 40);
                            default:    gap_left = $urandom_range(1, 5);
                        endcase
                    end
                end
            end
        end
    end

    // Response stall: changing patterns, plus one long hold-off while requests keep coming.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (hold_armed && rsp_done >= HOLD_AFTER_RSP)
        begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            stall_tick++;
            case (stall_mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= ($urandom_range(0, 99) < 35);
                2:       rsp_stall <= ((stall_tick % 5) < 2);
                default: rsp_stall <= ($urandom_range(0, 99) < 80);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_done++;
            if (rsp_owed.size() == 0)
                report_mismatch("unrequested response", 64'(rsp), 64'(0));
            else
            begin
                want = rsp_owed.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", 64'(rsp.status), 64'(want.status));
                if (rsp.read_data !== want.read_data)
                    report_mismatch("read_data", 64'(rsp.read_data), 64'(want.read_data));
                if (rsp.found_position !== want.found_position)
                    report_mismatch("found_position", 64'(rsp.found_position),
                                    64'(want.found_position));
                if (rsp.item_count !== want.item_count)
                    report_mismatch("item_count", 64'(rsp.item_count),
                                    64'(want.item_count));
            end
        end
    end

    initial
    begin
        #60000000;
        $display("FAIL indexed_list_store_core");
        $finish;
    end

    initial
    begin
        // Empty list, then a short list with a duplicate value and removals.
        plan_req(ils_pkg::OP_FIND, 0, 32'h0000_0000);
        plan_req(ils_pkg::OP_GET, 0, 32'h0);
        plan_req(ils_pkg::OP_SET, 0, 32'hDEAD_BEEF);
        plan_req(ils_pkg::OP_POP, 0, 32'h0);
        plan_req(ils_pkg::OP_APPEND, 0, 32'h0000_0000);
        plan_req(ils_pkg::OP_APPEND, 0, 32'hFFFF_FFFF);
        plan_req(ils_pkg::OP_APPEND, 0, 32'h1234_5678);
        plan_req(ils_pkg::OP_GET, 0, 32'h0);
        plan_req(ils_pkg::OP_GET, 1, 32'h0);
        plan_req(ils_pkg::OP_GET, 2, 32'h0);
        plan_req(ils_pkg::OP_GET, 3, 32'h0);
        plan_req(ils_pkg::OP_GET, 255, 32'hFFFF_FFFF);
        plan_req(ils_pkg::OP_SET, 1, 32'hA5A5_A5A5);
        plan_req(ils_pkg::OP_FIND, 0, 32'hFFFF_FFFF);
        plan_req(ils_pkg::OP_FIND, 0, 32'h1234_5678);
        plan_req(ils_pkg::OP_FIND, 255, 32'h0000_0000);
        plan_req(ils_pkg::OP_APPEND, 0, 32'h1234_5678);
        plan_req(ils_pkg::OP_FIND, 0, 32'h1234_5678);
        plan_req(ils_pkg::OP_POP, 1, 32'h0);
        plan_req(ils_pkg::OP_POP, 2, 32'h0);
        plan_req(ils_pkg::OP_POP, 5, 32'h0);
        plan_req(3'(FIRST_UNUSED_OP), 255, 32'hFFFF_FFFF);
        plan_req(3'(FIRST_UNUSED_OP + 1), 1, 32'h8000_0001);
        plan_req(3'(FIRST_UNUSED_OP + 2), 0, 32'h7FFF_FFFE);
        plan_req(ils_pkg::OP_GET, 1, 32'h0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // Growing mix; the long response hold-off lands in here.
        plan_random(300, 45, 15);
        wait_idle();

        // Fill to capacity, then work the full list at its extremes.
        while (plan_count < ils_pkg::DEPTH)
        begin
            if ($urandom_range(0, 4) == 0)
                plan_req(($urandom_range(0, 1) != 0) ? ils_pkg::OP_GET : ils_pkg::OP_FIND,
                         pick_pos(), pick_value());
            else
                plan_req(ils_pkg::OP_APPEND, 0, pick_value());
        end
        plan_req(ils_pkg::OP_APPEND, 0, 32'hFFFF_FFFF);
        plan_req(ils_pkg::OP_APPEND, 0, 32'h0000_0000);
        plan_req(ils_pkg::OP_GET, 255, 32'h0);
        plan_req(ils_pkg::OP_SET, 255, 32'hFFFF_FFFF);
        plan_req(ils_pkg::OP_FIND, 0, $urandom);
        plan_req(ils_pkg::OP_POP, 0, 32'h0);
        plan_req(ils_pkg::OP_APPEND, 0, 32'h8000_0000);
        plan_req(ils_pkg::OP_APPEND, 0, 32'h0000_0001);
        plan_req(ils_pkg::OP_POP, 255, 32'h0);
        plan_req(ils_pkg::OP_GET, 255, 32'h0);
        plan_req(ils_pkg::OP_APPEND, 0, pick_value());
        plan_req(ils_pkg::OP_FIND, 0, 32'h8000_0000);
        wait_idle();

        // Shrinking mixes down to an empty list, then a balanced tail.
        plan_random(200, 10, 45);
        wait_idle();
        while (plan_count > 0)
            plan_random(1, 10, 60);
        plan_random(150, 35, 30);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (rsp_owed.size() != 0)
            report_mismatch("responses still owed", 64'(rsp_owed.size()), 64'(0));

        $display("Covered %0d requests: %0d append, %0d get, %0d set, %0d pop, %0d find,",
                 op_tally.sum(), op_tally[ils_pkg::OP_APPEND], op_tally[ils_pkg::OP_GET],
                 op_tally[ils_pkg::OP_SET], op_tally[ils_pkg::OP_POP],
                 op_tally[ils_pkg::OP_FIND]);
        $display("%0d other codes; list peaked at %0d, %0d full refusals, %0d failed finds.",
                 op_tally[5] + op_tally[6] + op_tally[7], peak_count, full_refusals,
                 find_misses);
        if (mismatch_count == 0)
            $display("PASS indexed_list_store_core");
        else
            $display("FAIL indexed_list_store_core");
        $finish;
    end

endmodule

// File: indexed_list_store_core.f
design/ils_pkg.sv
design/ils_ram.sv
design/ils_ctrl.sv
design/ils_dp.sv
design/indexed_list_store_core.sv
design/ils_chk.sv
test/indexed_list_store_core_tb.sv
